// ----- hdl/obhb_pkg.sv -----
// Shared types and constants for the overwriting byte history buffer.
// Holds sizes, opcode and status codes, payload structs and the
// controller-to-datapath command and status structs. No dependencies.
package obhb_pkg;

   localparam int DEPTH     = 4096;
   localparam int MAX_READ  = 64;
   localparam int POS_W     = 48;
   localparam int CAP_W     = 13;
   localparam int CNT_W     = 7;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CAP_LIMIT = (DEPTH < (2 ** CAP_W) - 1) ? DEPTH : (2 ** CAP_W) - 1;
   localparam int CAP_RESET = (CAP_LIMIT < 4096) ? CAP_LIMIT : 4096;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_CLOSE = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DATA     = 2'd0,
      ST_CLOSED   = 2'd1,
      ST_NOT_YET  = 2'd2,
      ST_REJECTED = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [7:0]       data_byte;
      logic [POS_W-1:0] read_begin;
      logic [CNT_W-1:0] read_count;
   } req_payload_type;

   typedef struct packed {
      status_type       status;
      logic [7:0]       out_byte;
      logic [POS_W-1:0] position;
      logic             last;
   } rsp_payload_type;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_CMP    = 8'b0000_0010,
      S_OFS    = 8'b0000_0100,
      S_LEN    = 8'b0000_1000,
      S_SET    = 8'b0001_0000,
      S_FETCH  = 8'b0010_0000,
      S_SEND   = 8'b0100_0000,
      S_STAT   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic do_write;
      logic do_close;
      logic load_read;
      logic calc_oldest;
      logic calc_offset;
      logic calc_start;
      logic calc_setup;
      logic fetch;
      logic send;
      logic send_status;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic unwritten;
      logic last_byte;
   } dp_status_type;

endpackage

// ----- hdl/overwriting_byte_history_buffer_core.sv -----
// A write or close: one item per cycle while the result side is free and no read is running.
// A read passes its setup states and a fetch, then gives one byte per cycle while the result
// side is free (a prefetch from the registered store read port); an unwritten read gets one status item.
// The next item is accepted once a read's last result is loaded and the result side is free.
// Synchronous active-high reset clears pointers, count, closed flag and sets capacity to 4096;
// the byte store is not cleared and needs no clearing pass.
module overwriting_byte_history_buffer_core import obhb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_payload_type  req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_payload_type  rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   cmd_type       cmd;
   dp_status_type dp_stat;

   obhb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_payload.opcode),
      .dp_stat    (dp_stat),
      .cmd        (cmd)
   );

   obhb_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .dp_stat     (dp_stat),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

endmodule

// ----- hdl/obhb_ctrl.sv -----
// Sequencer for the history buffer: accepts items and steps a read
// through its setup and byte-send phases. Depends on obhb_pkg.
module obhb_ctrl import obhb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_opcode,
   input  dp_status_type dp_stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      fire;

   assign req_stall = !((state_ff == S_IDLE) && dp_stat.out_free);
   assign fire      = req_valid && !req_stall;

   always_comb begin
      cmd             = '0;
      cmd.do_write    = fire && (req_opcode == OP_WRITE);
      cmd.do_close    = fire && (req_opcode == OP_CLOSE);
      cmd.load_read   = fire && (req_opcode == OP_READ);
      cmd.calc_oldest = (state_ff == S_CMP);
      cmd.calc_offset = (state_ff == S_OFS);
      cmd.calc_start  = (state_ff == S_LEN);
      cmd.calc_setup  = (state_ff == S_SET);
      cmd.fetch       = (state_ff == S_FETCH);
      cmd.send        = (state_ff == S_SEND) && dp_stat.out_free;
      cmd.send_status = (state_ff == S_STAT) && dp_stat.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load_read) state_in = S_CMP;
         end
         S_CMP:   state_in = S_OFS;
         S_OFS: begin
            state_in = dp_stat.unwritten ? S_STAT : S_LEN;
         end
         S_LEN:   state_in = S_SET;
         S_SET:   state_in = S_FETCH;
         S_FETCH: state_in = S_SEND;
         S_SEND: begin
            if (dp_stat.out_free && dp_stat.last_byte) state_in = S_IDLE;
         end
         S_STAT: begin
            if (dp_stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/obhb_datapath.sv -----
// Datapath of the history buffer: byte store, ring pointers, stream count,
// read address setup and the result register. Depends on obhb_pkg.
module obhb_datapath import obhb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output dp_status_type   dp_stat,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   logic [7:0]       mem [DEPTH];

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] head_ff;
   logic [CAP_W-1:0] fill_ff;
   logic [POS_W-1:0] total_ff;
   logic             closed_ff;

   logic [POS_W-1:0] begin_ff;
   logic [CNT_W-1:0] count_ff;
   logic [POS_W-1:0] oldest_ff;
   logic             unwritten_ff;
   logic [POS_W-1:0] diff_ff;
   logic             after_ff;
   logic [CAP_W-1:0] start_ff;
   logic [CNT_W-1:0] remain_ff;
   logic [CAP_W-1:0] idx_ff;
   logic [POS_W-1:0] pos_ff;
   logic [7:0]       rd_data_ff;

   rsp_payload_type  rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_load;
   logic             out_free;

   logic             full;
   logic [CAP_W:0]   tail_sum;
   logic [CAP_W-1:0] tail;
   logic [CAP_W:0]   head_inc;
   logic [CAP_W-1:0] head_next;
   logic [CAP_W:0]   setup_sum;
   logic [CAP_W-1:0] setup_idx;
   logic [CAP_W-1:0] avail;
   logic [CAP_W:0]   idx_inc;
   logic [CAP_W-1:0] idx_next;
   logic [CNT_W-1:0] count_sat;
   logic [CAP_W-1:0] cap_clamped;
   logic             write_ok;
   logic             rd_en;
   logic [CAP_W-1:0] rd_idx;

   assign out_free          = !rsp_valid_ff || !rsp_stall;
   assign dp_stat.out_free  = out_free;
   assign dp_stat.unwritten = unwritten_ff;
   assign dp_stat.last_byte = (remain_ff == CNT_W'(1));
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload       = rsp_ff;
   assign csr_ready         = 1'b1;

   // ring arithmetic: every sum stays below twice the capacity
   always_comb begin
      full      = (fill_ff >= capacity_ff);
      head_inc  = {1'b0, head_ff} + (CAP_W+1)'(1);
      head_next = (head_inc >= {1'b0, capacity_ff}) ? '0 : head_inc[CAP_W-1:0];
      tail_sum  = {1'b0, head_ff} + {1'b0, fill_ff};
      if (full) begin
         tail = head_ff;
      end else if (tail_sum >= {1'b0, capacity_ff}) begin
         tail = CAP_W'(tail_sum - {1'b0, capacity_ff});
      end else begin
         tail = tail_sum[CAP_W-1:0];
      end
      setup_sum = {1'b0, head_ff} + {1'b0, start_ff};
      setup_idx = (setup_sum >= {1'b0, capacity_ff}) ?
                  CAP_W'(setup_sum - {1'b0, capacity_ff}) : setup_sum[CAP_W-1:0];
      avail     = fill_ff - start_ff;
      idx_inc   = {1'b0, idx_ff} + (CAP_W+1)'(1);
      idx_next  = (idx_inc >= {1'b0, capacity_ff}) ? '0 : idx_inc[CAP_W-1:0];
   end

   always_comb begin
      count_sat = req_payload.read_count;
      if (req_payload.read_count == '0) begin
         count_sat = CNT_W'(1);
      end else if (req_payload.read_count > CNT_W'(MAX_READ)) begin
         count_sat = CNT_W'(MAX_READ);
      end
      cap_clamped = csr_data;
      if (csr_data == '0) begin
         cap_clamped = CAP_W'(1);
      end else if (csr_data > CAP_W'(CAP_LIMIT)) begin
         cap_clamped = CAP_W'(CAP_LIMIT);
      end
   end

   assign write_ok = cmd.do_write && !closed_ff;

   // buffer state
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(CAP_RESET);
         head_ff     <= '0;
         fill_ff     <= '0;
         total_ff    <= '0;
         closed_ff   <= 1'b0;
      end else begin
         if (csr_valid && (total_ff == '0) && !closed_ff) begin
            capacity_ff <= cap_clamped;
         end
         if (write_ok) begin
            if (full) begin
               head_ff <= head_next;
            end else begin
               fill_ff <= fill_ff + CAP_W'(1);
            end
            total_ff <= total_ff + POS_W'(1);
         end
         if (cmd.do_close) begin
            closed_ff <= 1'b1;
         end
      end
   end

   // read setup and byte walk
   always_ff @(posedge clock) begin
      if (cmd.load_read) begin
         begin_ff <= req_payload.read_begin;
         count_ff <= count_sat;
      end
      if (cmd.calc_oldest) begin
         oldest_ff    <= total_ff - POS_W'(fill_ff);
         unwritten_ff <= !(begin_ff < total_ff);
      end
      if (cmd.calc_offset) begin
         diff_ff  <= begin_ff - oldest_ff;
         after_ff <= (begin_ff > oldest_ff);
      end
      if (cmd.calc_start) begin
         start_ff <= (after_ff && (diff_ff < POS_W'(fill_ff))) ? diff_ff[CAP_W-1:0] : '0;
      end
      if (cmd.calc_setup) begin
         remain_ff <= (CAP_W'(count_ff) < avail) ? count_ff : avail[CNT_W-1:0];
         idx_ff    <= setup_idx;
         pos_ff    <= oldest_ff + POS_W'(start_ff);
      end
      if (cmd.send) begin
         remain_ff <= remain_ff - CNT_W'(1);
         idx_ff    <= idx_next;
         pos_ff    <= pos_ff + POS_W'(1);
      end
   end

   // fetch the current byte, or prefetch the next one while sending
   assign rd_en  = cmd.fetch || (cmd.send && !dp_stat.last_byte);
   assign rd_idx = cmd.fetch ? idx_ff : idx_next;

   always_ff @(posedge clock) begin
      if (write_ok) begin
         mem[ADDR_W'(tail)] <= req_payload.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[ADDR_W'(rd_idx)];
      end
   end

   // result register
   always_comb begin
      rsp_load = 1'b0;
      rsp_in   = rsp_ff;
      if (cmd.do_write && closed_ff) begin
         rsp_load        = 1'b1;
         rsp_in.status   = ST_REJECTED;
         rsp_in.out_byte = '0;
         rsp_in.position = total_ff;
         rsp_in.last     = 1'b1;
      end else if (cmd.send) begin
         rsp_load        = 1'b1;
         rsp_in.status   = ST_DATA;
         rsp_in.out_byte = rd_data_ff;
         rsp_in.position = pos_ff;
         rsp_in.last     = dp_stat.last_byte;
      end else if (cmd.send_status) begin
         rsp_load        = 1'b1;
         rsp_in.status   = closed_ff ? ST_CLOSED : ST_NOT_YET;
         rsp_in.out_byte = '0;
         rsp_in.position = begin_ff;
         rsp_in.last     = 1'b1;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hdl/obhb_checker.sv -----
// Port-level checks for the history buffer core, bound to the top level.
// Depends on obhb_pkg and overwriting_byte_history_buffer_core.
module obhb_checker import obhb_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   logic             pend_ff;
   logic [POS_W-1:0] ppos_ff;

   // track a read that has delivered a byte but not its last one
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         ppos_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         pend_ff <= (rsp_payload.status == ST_DATA) && !rsp_payload.last;
         ppos_ff <= rsp_payload.position;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != ST_DATA) |->
      rsp_payload.last && (rsp_payload.out_byte == 8'd0))
      else $error("status item not a single last item");

   a_pos_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pend_ff |->
      (rsp_payload.status == ST_DATA) && (rsp_payload.position == ppos_ff + POS_W'(1)))
      else $error("read bytes not at consecutive positions");

   a_busy_read: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !rsp_valid |-> req_stall)
      else $error("item accepted in the middle of a read");

endmodule

bind overwriting_byte_history_buffer_core obhb_checker u_obhb_checker (.*);

// ----- dv/overwriting_byte_history_buffer_core_tb.sv -----
// Self-checking testbench for overwriting_byte_history_buffer_core.
// Depends on obhb_pkg and the core RTL; drives writes, reads and closes with random
// sender gaps and receiver stalls, and checks every byte against its own history model.
module overwriting_byte_history_buffer_core_tb;
   import obhb_pkg::*;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_BURST
   } stall_mode_type;

   class byte_history_scoreboard;
      logic [7:0]       byte_store [DEPTH];
      int unsigned      head_index;
      int unsigned      fill_level;
      int unsigned      capacity;
      logic [POS_W-1:0] total_written;
      bit               closed;
      rsp_payload_type  awaited_rsp [$];
      int               failures;

      function new();
         head_index    = 0;
         fill_level    = 0;
         capacity      = CAP_RESET;
         total_written = '0;
         closed        = 1'b0;
         failures      = 0;
      endfunction

      function void apply_capacity(input logic [CAP_W-1:0] value);
         if (total_written != 0 || closed) return;
         if (value < 1) capacity = 1;
         else if (value > DEPTH) capacity = DEPTH;
         else capacity = 32'(value);
      endfunction

      function void push_status(input status_type st, input logic [POS_W-1:0] pos);
         rsp_payload_type rsp;
         rsp.status   = st;
         rsp.out_byte = 8'h00;
         rsp.position = pos;
         rsp.last     = 1'b1;
         awaited_rsp.push_back(rsp);
      endfunction

      function void note_request(input req_payload_type item);
         int unsigned      count;
         int unsigned      avail;
         int unsigned      n;
         logic [POS_W-1:0] oldest;
         logic [POS_W-1:0] start;
         rsp_payload_type  rsp;
         case (item.opcode)
            OP_WRITE: begin
               if (closed) begin
                  push_status(ST_REJECTED, total_written);
               end else begin
                  // drop the oldest byte once full
                  if (fill_level >= capacity) begin
                     head_index = (head_index + 1) % capacity;
                     fill_level = capacity - 1;
                  end
                  byte_store[ADDR_W'((head_index + fill_level) % capacity)] = item.data_byte;
                  fill_level++;
                  total_written = total_written + 1'b1;
               end
            end
            OP_READ: begin
               count = 32'(item.read_count);
               if (count < 1) count = 1;
               if (count > MAX_READ) count = MAX_READ;
               if (!(item.read_begin < total_written)) begin
                  push_status(closed ? ST_CLOSED : ST_NOT_YET, item.read_begin);
               end else begin
                  oldest = total_written - POS_W'(fill_level);
                  start  = (item.read_begin <= oldest) ? '0 : item.read_begin - oldest;
                  if (start >= fill_level) start = '0;
                  avail = fill_level - int'(start);
                  n     = (count < avail) ? count : avail;
                  for (int unsigned i = 0; i < n; i++) begin
                     rsp.status   = ST_DATA;
                     rsp.out_byte =
                        byte_store[ADDR_W'((head_index + int'(start) + i) % capacity)];
                     rsp.position = oldest + start + POS_W'(i);
                     rsp.last     = (i + 1 == n);
                     awaited_rsp.push_back(rsp);
                  end
               end
            end
            OP_CLOSE: closed = 1'b1;
            default: ;
         endcase
      endfunction

      function void check_response(input rsp_payload_type actual);
         rsp_payload_type want;
         if (awaited_rsp.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response: status=%0d byte=%02h pos=%0d last=%0b",
                        actual.status, actual.out_byte, actual.position, actual.last);
            return;
         end
         want = awaited_rsp.pop_front();
         if (actual.status !== want.status || actual.out_byte !== want.out_byte ||
             actual.position !== want.position || actual.last !== want.last) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected status=%0d byte=%02h pos=%0d last=%0b,",
                        want.status, want.out_byte, want.position, want.last,
                        " got status=%0d byte=%02h pos=%0d last=%0b",
                        actual.status, actual.out_byte, actual.position, actual.last);
         end
      endfunction

      function void flag_leftovers();
         if (awaited_rsp.size() != 0) begin
            failures += awaited_rsp.size();
            $display("%0d expected responses never arrived", awaited_rsp.size());
         end
      endfunction
   endclass

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   req_payload_type  req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   rsp_payload_type  rsp_payload;
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data    = '0;

   byte_history_scoreboard sb;
   int                     burst_left = 0;
   stall_mode_type         stall_mode = STALL_NONE;
   int                     stall_phase_left = 0;
   int                     stall_run = 0;

   overwriting_byte_history_buffer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_request(req_payload);
      if (!reset && csr_valid && csr_ready) sb.apply_capacity(csr_data);
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_payload);
   end

   // receiver back-pressure: switch between free, random, periodic and burst stalls
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode       = stall_mode_type'($urandom_range(0, 3));
         stall_phase_left = $urandom_range(16, 160);
      end
      stall_phase_left--;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_PERIODIC: rsp_stall <= (stall_phase_left % 4 == 1);
         default: begin
            if (stall_run == 0 && $urandom_range(0, 9) == 0) stall_run = $urandom_range(1, 8);
            rsp_stall <= (stall_run != 0);
            if (stall_run != 0) stall_run--;
         end
      endcase
   end

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(input req_payload_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_payload <= item;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_op(input opcode_type op, input logic [7:0] data,
                          input logic [POS_W-1:0] begin_pos, input logic [CNT_W-1:0] count);
      req_payload_type item;
      item.opcode     = op;
      item.data_byte  = data;
      item.read_begin = begin_pos;
      item.read_count = count;
      send_item(item);
   endtask

   // hold off until every expected response is in and the core has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.awaited_rsp.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic req_payload_type random_request(input bit allow_close);
      req_payload_type item;
      int unsigned     pick;
      item.opcode     = OP_WRITE;
      item.data_byte  = 8'($urandom);
      item.read_begin = POS_W'({$urandom, $urandom});
      item.read_count = CNT_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         item.opcode = OP_WRITE;
      end else if (pick < 94) begin
         item.opcode = OP_READ;
         pick = $urandom_range(0, 99);
         if (pick < 60)
            item.read_begin = sb.total_written - POS_W'($urandom_range(1, sb.fill_level + 3));
         else if (pick < 75)
            item.read_begin = sb.total_written + POS_W'($urandom_range(0, 3));
         else if (pick < 90)
            item.read_begin = POS_W'({$urandom, $urandom});
         else
            item.read_begin = '0;
         pick = $urandom_range(0, 99);
         if (pick < 70) item.read_count = CNT_W'($urandom_range(1, MAX_READ));
         else if (pick < 85) item.read_count = CNT_W'($urandom_range(MAX_READ + 1, 127));
         else if (pick < 90) item.read_count = '0;
         else item.read_count = CNT_W'(MAX_READ);
      end else if (pick < 97) begin
         item.opcode = OP_NONE;
      end else begin
         item.opcode = allow_close ? OP_CLOSE : OP_WRITE;
      end
      return item;
   endfunction

   task automatic run_random(input int items, input bit allow_close);
      req_payload_type item;
      int              sent;
      sent = 0;
      while (sent < items) begin
         item = random_request(allow_close);
         send_item(item);
         if (item.opcode != OP_NONE) sent++;
      end
   endtask

   initial begin
      logic [CAP_W-1:0] cap_value;
      int               sel;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // saturate at both ends, then settle on the capacity for this run
      sel = $urandom_range(0, 7);
      if (sel == 0) cap_value = '0;
      else if (sel == 1) cap_value = '1;
      else cap_value = CAP_W'($urandom_range(40, 100));
      write_capacity('0);
      write_capacity('1);
      write_capacity(cap_value);

      send_op(OP_READ, 8'h00, '0, 7'd1);
      send_op(OP_READ, 8'hFF, '1, '1);
      send_op(OP_NONE, '1, '1, '1);
      send_op(OP_WRITE, 8'h00, '0, '0);
      send_op(OP_WRITE, 8'hFF, '1, '1);
      send_op(OP_WRITE, 8'hA5, '0, '0);
      send_op(OP_WRITE, 8'h5A, '0, '0);
      send_op(OP_READ, 8'h00, '0, '0);
      send_op(OP_READ, 8'h00, '0, 7'(MAX_READ));
      send_op(OP_READ, 8'h00, sb.total_written, 7'd5);
      send_op(OP_READ, 8'h00, 48'd2, '1);
      for (int i = 0; i < 6; i++) send_op(OP_WRITE, 8'(i * 37 + 1), '0, '0);
      send_op(OP_READ, 8'h00, '0, 7'(MAX_READ));

      run_random(260, 1'b0);
      drain();
      // capacity is locked once bytes are in
      write_capacity('0);
      write_capacity(13'd4096);
      run_random(140, 1'b0);
      drain();

      send_op(OP_CLOSE, '0, '0, '0);
      send_op(OP_CLOSE, '1, '1, '1);
      send_op(OP_WRITE, 8'hFF, '0, '0);
      send_op(OP_READ, 8'h00, sb.total_written, 7'd1);
      send_op(OP_READ, 8'h00, '1, 7'd3);
      send_op(OP_READ, 8'h00, '0, 7'(MAX_READ));
      drain();
      write_capacity(13'd7);
      run_random(60, 1'b1);

      drain();
      repeat (8) @(posedge clock);
      sb.flag_leftovers();
      if (sb.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/obhb_pkg.sv
hdl/obhb_ctrl.sv
hdl/obhb_datapath.sv
hdl/overwriting_byte_history_buffer_core.sv
hdl/obhb_checker.sv
dv/overwriting_byte_history_buffer_core_tb.sv
